// ===== src/crsa_pkg.sv =====
// Shared types and constants for the command ring space allocator.
package crsa_pkg;

    // Field widths of the request and result ports
    localparam int LEN_W    = 24;
    localparam int OFFSET_W = 21;
    localparam int RLEN_W   = 17;
    localparam int CNT_W    = 32;

    // Internal widths, sized for the largest ring and data area supported
    localparam int RND_W  = 25;  // rounded length before range check
    localparam int HEAD_W = 21;  // ring head, holds up to the full ring size
    localparam int PTR_W  = 26;  // data pointer and aligned end sums

    // Request kinds
    typedef enum logic [1:0] {
        REQ_PACKET = 2'd0,
        REQ_DATA   = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_FENCE  = 2'd3
    } req_kind_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        req_kind_t             kind;
        logic                  pkt_ok;   // rounded length within header..ring
        logic [HEAD_W-1:0]     rlen;     // rounded packet length
        logic                  dlen_ok;  // data length within data area size
        logic [LEN_W-1:0]      dlen;     // data length
    } cmd_t;

    // Result of one request
    typedef struct packed {
        logic                  granted;
        logic [OFFSET_W-1:0]   offset;
        logic [RLEN_W-1:0]     rounded_length;
        logic [CNT_W-1:0]      fence_value;
        logic                  doorbell;
        logic [RLEN_W-1:0]     batch_length;
        logic [CNT_W-1:0]      packets_total;
        logic [CNT_W-1:0]      batches_total;
    } rsp_t;

endpackage

// ===== src/command_ring_space_allocator.sv =====
// A request waits in the command queue, the back end settles it, and its result waits in
// the result queue, showing on the result ports until popped. Throughput: one request per
// cycle unless a queue is full; the back end settles each request combinationally against
// the ring head and data pointer, and two-entry queues on both sides absorb stalls.
// Reset (rst_n, asynchronous, active low): ring head 0, data pointer at the data base,
// fence, packet and batch counts 0, both queues empty.
module command_ring_space_allocator
    import crsa_pkg::*;
    #(
        parameter int RING_BYTES   = 65536,
        parameter int DATA_BASE    = 65536,
        parameter int DATA_BYTES   = 1048576,
        parameter int HEADER_BYTES = 8
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                push,
        output logic                full,
        input  logic [1:0]          req_type,
        input  logic [LEN_W-1:0]    length_bytes,
        output logic                empty,
        input  logic                pop,
        output logic                granted,
        output logic [OFFSET_W-1:0] offset,
        output logic [RLEN_W-1:0]   rounded_length,
        output logic [CNT_W-1:0]    fence_value,
        output logic                doorbell,
        output logic [RLEN_W-1:0]   batch_length,
        output logic [CNT_W-1:0]    packets_total,
        output logic [CNT_W-1:0]    batches_total
    );

    cmd_t cmd;
    logic cmd_empty;
    logic cmd_pop;
    rsp_t rsp;
    logic rsp_push;
    logic rsp_full;
    rsp_t rsp_out;

    // Request intake and classification
    crsa_front
    #(
        .RING_BYTES   (RING_BYTES),
        .DATA_BYTES   (DATA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .length_bytes (length_bytes),
        .cmd_pop      (cmd_pop),
        .cmd_empty    (cmd_empty),
        .cmd          (cmd)
    );

    // Allocation against ring and data pointers
    crsa_back
    #(
        .RING_BYTES (RING_BYTES),
        .DATA_BASE  (DATA_BASE),
        .DATA_BYTES (DATA_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_full  (rsp_full),
        .rsp_push  (rsp_push),
        .rsp       (rsp)
    );

    // Result queue
    crsa_fifo #(.T(rsp_t)) u_rsp_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .full  (rsp_full),
        .wdata (rsp),
        .pop   (pop),
        .empty (empty),
        .rdata (rsp_out)
    );

    assign granted        = rsp_out.granted;
    assign offset         = rsp_out.offset;
    assign rounded_length = rsp_out.rounded_length;
    assign fence_value    = rsp_out.fence_value;
    assign doorbell       = rsp_out.doorbell;
    assign batch_length   = rsp_out.batch_length;
    assign packets_total  = rsp_out.packets_total;
    assign batches_total  = rsp_out.batches_total;

endmodule

// ===== src/crsa_fifo.sv =====
// Two-entry queue used between the front and back and on the result side.
module crsa_fifo
    #(
        parameter type T = logic
    )
    (
        input  logic clk,
        input  logic rst_n,
        input  logic push,
        output logic full,
        input  T     wdata,
        input  logic pop,
        output logic empty,
        output T     rdata
    );

    T           mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/crsa_front.sv =====
// Front end: accepts requests, rounds and range-checks lengths, queues them.
module crsa_front
    import crsa_pkg::*;
    #(
        parameter int RING_BYTES   = 65536,
        parameter int DATA_BYTES   = 1048576,
        parameter int HEADER_BYTES = 8
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        output logic             full,
        input  logic [1:0]       req_type,
        input  logic [LEN_W-1:0] length_bytes,
        input  logic             cmd_pop,
        output logic             cmd_empty,
        output cmd_t             cmd
    );

    localparam logic [RND_W-1:0] HDR_C  = RND_W'(HEADER_BYTES);
    localparam logic [RND_W-1:0] RING_C = RND_W'(RING_BYTES);
    localparam logic [RND_W-1:0] DATA_C = RND_W'(DATA_BYTES);
    localparam logic [RND_W-1:0] ALIGN8 = RND_W'(7);

    logic [RND_W-1:0] len_ext;
    logic [RND_W-1:0] rounded;
    cmd_t             cmd_in;

    // Round up to 8 bytes and check sizes that do not depend on state
    always_comb
    begin
        len_ext        = {1'b0, length_bytes};
        rounded        = (len_ext + ALIGN8) & ~ALIGN8;
        cmd_in.kind    = req_kind_t'(req_type);
        cmd_in.pkt_ok  = (rounded >= HDR_C) && (rounded <= RING_C);
        cmd_in.rlen    = rounded[HEAD_W-1:0];
        cmd_in.dlen_ok = (len_ext <= DATA_C);
        cmd_in.dlen    = length_bytes;
    end

    // Queue toward the back end
    crsa_fifo #(.T(cmd_t)) u_cmd_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd)
    );

endmodule

// ===== src/crsa_back.sv =====
// Back end: holds ring and data pointers and counters, grants or refuses requests.
module crsa_back
    import crsa_pkg::*;
    #(
        parameter int RING_BYTES = 65536,
        parameter int DATA_BASE  = 65536,
        parameter int DATA_BYTES = 1048576
    )
    (
        input  logic clk,
        input  logic rst_n,
        input  logic cmd_empty,
        input  cmd_t cmd,
        output logic cmd_pop,
        input  logic rsp_full,
        output logic rsp_push,
        output rsp_t rsp
    );

    localparam logic [HEAD_W:0]  RING_C  = (HEAD_W+1)'(RING_BYTES);
    localparam logic [PTR_W-1:0] BASE_C  = PTR_W'(DATA_BASE);
    localparam logic [PTR_W-1:0] END_C   = PTR_W'(DATA_BASE + DATA_BYTES);
    localparam logic [PTR_W-1:0] ALIGN_M = PTR_W'(255);

    logic [HEAD_W-1:0] head_reg;
    logic [HEAD_W-1:0] head_next;
    logic [PTR_W-1:0]  dptr_reg;
    logic [PTR_W-1:0]  dptr_next;
    logic [CNT_W-1:0]  fence_reg;
    logic [CNT_W-1:0]  fence_next;
    logic [CNT_W-1:0]  pkts_reg;
    logic [CNT_W-1:0]  pkts_next;
    logic [CNT_W-1:0]  batches_reg;
    logic [CNT_W-1:0]  batches_next;

    logic              fire;
    logic [HEAD_W:0]   head_sum;
    logic              pkt_grant;
    logic [PTR_W-1:0]  data_off;
    logic [PTR_W-1:0]  data_sum;
    logic              data_grant;

    assign fire     = !cmd_empty && !rsp_full;
    assign cmd_pop  = fire;
    assign rsp_push = fire;

    // Fit checks against current pointers
    always_comb
    begin
        head_sum   = {1'b0, head_reg} + {1'b0, cmd.rlen};
        pkt_grant  = cmd.pkt_ok && (head_sum <= RING_C);
        data_off   = (dptr_reg + ALIGN_M) & ~ALIGN_M;
        data_sum   = data_off + PTR_W'(cmd.dlen);
        data_grant = cmd.dlen_ok && (data_sum <= END_C);
    end

    // Request execution and next state
    always_comb
    begin
        head_next    = head_reg;
        dptr_next    = dptr_reg;
        fence_next   = fence_reg;
        pkts_next    = pkts_reg;
        batches_next = batches_reg;
        rsp          = '0;

        unique case (cmd.kind) inside
            REQ_PACKET, REQ_FENCE:
            begin
                if (pkt_grant)
                begin
                    head_next          = head_sum[HEAD_W-1:0];
                    pkts_next          = pkts_reg + CNT_W'(1);
                    rsp.granted        = 1'b1;
                    rsp.offset         = OFFSET_W'(head_reg);
                    rsp.rounded_length = RLEN_W'(cmd.rlen);
                    if (cmd.kind == REQ_FENCE)
                    begin
                        fence_next      = fence_reg + CNT_W'(1);
                        rsp.fence_value = fence_next;
                    end
                end
            end
            REQ_DATA:
            begin
                if (data_grant)
                begin
                    dptr_next   = data_sum;
                    rsp.granted = 1'b1;
                    rsp.offset  = OFFSET_W'(data_off);
                end
            end
            REQ_FLUSH:
            begin
                if (head_reg != '0)
                begin
                    rsp.doorbell     = 1'b1;
                    rsp.batch_length = RLEN_W'(head_reg);
                    batches_next     = batches_reg + CNT_W'(1);
                    head_next        = '0;
                    dptr_next        = BASE_C;
                end
            end
            default:
            begin
            end
        endcase

        rsp.packets_total = pkts_next;
        rsp.batches_total = batches_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            dptr_reg    <= BASE_C;
            fence_reg   <= '0;
            pkts_reg    <= '0;
            batches_reg <= '0;
        end
        else if (fire)
        begin
            head_reg    <= head_next;
            dptr_reg    <= dptr_next;
            fence_reg   <= fence_next;
            pkts_reg    <= pkts_next;
            batches_reg <= batches_next;
        end
    end

endmodule
